>>> rtl/core/rktt_pkg.sv
// Shared constants for the remote key translation table.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps

package rktt_pkg;

	// Table geometry.
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = IDX_W + 1;

	// Field widths.
	localparam int PID_W   = 22;
	localparam int KEY_W   = 32;
	localparam int ENTRY_W = PID_W + KEY_W + KEY_W;

	// Action codes.
	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_DELETE   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP   = 2'd2;

	// Translated key reported on a miss and for non-lookup actions.
	localparam logic [KEY_W-1:0] MISS_KEY = {KEY_W{1'b1}};

	// Status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Entry record as held in the RAM.
	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [KEY_W-1:0] vkey;
		logic [KEY_W-1:0] rkey;
	} entry_t;

endpackage

>>> rtl/core/rktt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth are parameters.
`timescale 1ns / 1ps

module rktt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/remote_key_translation_table.sv
// Remote key translation table: exact match on (process id, virtual key).
// Each word is handled by one sequential scan through the entry RAM, one read per cycle.
// A new word is taken only once the last is done; busy is high from accept to done.
// Reset clears all valid marks at once in flip-flops; the RAM holds no reset.
// Each result is shown for one cycle on the done strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module remote_key_translation_table
	import rktt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       action,
	input  logic [PID_W-1:0] process_id,
	input  logic [KEY_W-1:0] virtual_key,
	input  logic [KEY_W-1:0] real_key,
	output logic             done,
	output logic             found,
	output logic [KEY_W-1:0] translated_key,
	output logic             status
);

	// Sequencer state codes.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;

	// Captured request word.
	logic [1:0]       act_q;
	logic [PID_W-1:0] pid_q;
	logic [KEY_W-1:0] vkey_q;
	logic [KEY_W-1:0] rkey_q;

	// Scan results.
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [KEY_W-1:0] hit_rkey_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [ENTRIES-1:0] valid_q;

	// Output registers.
	logic             done_q;
	logic             found_q;
	logic [KEY_W-1:0] xkey_q;
	logic             status_q;

	// RAM ports.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	logic accept;
	logic scan_issue;
	logic entry_match;
	logic last_chk;

	assign accept      = start && (state_q == ST_IDLE);
	assign scan_issue  = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ENTRIES));
	assign ram_raddr   = cnt_q[IDX_W-1:0];
	assign entry_match = chk_s1 && valid_q[idx_s1] &&
		(ram_rdata.pid == pid_q) && (ram_rdata.vkey == vkey_q);
	assign last_chk    = chk_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));

	// On a register, write back in the finish cycle: update in place or fill the free slot.
	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = free_idx_q;
		ram_wdata.pid  = pid_q;
		ram_wdata.vkey = vkey_q;
		ram_wdata.rkey = rkey_q;
		if ((state_q == ST_FIN) && (act_q == ACT_REGISTER)) begin
			if (hit_q) begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
			end else if (free_q) begin
				ram_we    = 1'b1;
			end
		end
	end

	rktt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer and scan pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			chk_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			chk_s1 <= scan_issue;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (last_chk) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Valid marks: set on a new entry, cleared on a delete hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == ST_FIN) begin
			if ((act_q == ACT_REGISTER) && !hit_q && free_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if ((act_q == ACT_DELETE) && hit_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Request capture, match and free-slot tracking, result formation.
	always_ff @(posedge clk) begin
		idx_s1 <= ram_raddr;
		if (accept) begin
			act_q  <= action;
			pid_q  <= process_id;
			vkey_q <= virtual_key;
			rkey_q <= real_key;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (entry_match) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= idx_s1;
				hit_rkey_q <= ram_rdata.rkey;
			end
			if (chk_s1 && !valid_q[idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_FIN) begin
			found_q  <= hit_q;
			xkey_q   <= ((act_q == ACT_LOOKUP) && hit_q) ? hit_rkey_q : MISS_KEY;
			status_q <= ((act_q == ACT_REGISTER) && !hit_q && !free_q) ?
				STATUS_FULL : STATUS_OK;
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign found          = found_q;
	assign translated_key = xkey_q;
	assign status         = status_q;

	// A result strobe lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for more than one cycle");

	// An accepted word makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a word");

	// Table full is only reported for a key that was absent.
	a_full_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !found)
		else $error("table full reported together with a hit");

	// A translated key other than the miss value implies a hit.
	a_xkey_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (translated_key != MISS_KEY)) |-> found)
		else $error("translated key given without a hit");

endmodule

>>> dv/remote_key_translation_table_tb.sv
// Self-checking testbench for the remote key translation table.
// Depends on rktt_pkg and remote_key_translation_table; it keeps its own copy of the table.
`timescale 1ns / 1ps

module remote_key_translation_table_tb;
	import rktt_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int KEY_POOL = 96;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		logic             found;
		logic [KEY_W-1:0] translated_key;
		logic             status;
	} translation_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       action;
	logic [PID_W-1:0] process_id;
	logic [KEY_W-1:0] virtual_key;
	logic [KEY_W-1:0] real_key;
	logic             done;
	logic             found;
	logic [KEY_W-1:0] translated_key;
	logic             status;

	// Shadow copy of the table contents.
	logic             slot_valid [ENTRIES];
	logic [PID_W-1:0] slot_pid   [ENTRIES];
	logic [KEY_W-1:0] slot_vkey  [ENTRIES];
	logic [KEY_W-1:0] slot_rkey  [ENTRIES];

	// Keys that random traffic reuses so that hits, deletes and a full table happen.
	logic [PID_W-1:0] pool_pid  [KEY_POOL];
	logic [KEY_W-1:0] pool_vkey [KEY_POOL];

	translation_t pending_translations[$];
	translation_t oldest_translation;

	int  errors;
	int  words_sent;
	int  results_checked;
	int  hits_predicted;
	int  full_predicted;
	int  quiet_cycles;
	bit  gaps_on;

	remote_key_translation_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.process_id    (process_id),
		.virtual_key   (virtual_key),
		.real_key      (real_key),
		.done          (done),
		.found         (found),
		.translated_key(translated_key),
		.status        (status)
	);

	// Free-running clock, 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one action to the shadow table and return the result it must give.
	function automatic translation_t predict_translation(input logic [1:0] act,
			input logic [PID_W-1:0] pid, input logic [KEY_W-1:0] vkey,
			input logic [KEY_W-1:0] rkey);
		translation_t res;
		int hit;
		int free_slot;
		hit = -1;
		free_slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && slot_valid[i] && slot_pid[i] == pid && slot_vkey[i] == vkey)
				hit = i;
			if (free_slot < 0 && !slot_valid[i])
				free_slot = i;
		end
		res.found = (hit >= 0);
		res.translated_key = MISS_KEY;
		res.status = STATUS_OK;
		case (act)
			ACT_REGISTER: begin
				if (hit >= 0) begin
					slot_rkey[hit] = rkey;
				end else if (free_slot >= 0) begin
					slot_valid[free_slot] = 1'b1;
					slot_pid[free_slot] = pid;
					slot_vkey[free_slot] = vkey;
					slot_rkey[free_slot] = rkey;
				end else begin
					res.status = STATUS_FULL;
				end
			end
			ACT_DELETE: begin
				if (hit >= 0)
					slot_valid[hit] = 1'b0;
			end
			ACT_LOOKUP: begin
				if (hit >= 0)
					res.translated_key = slot_rkey[hit];
			end
			default: ;
		endcase
		if (res.found)
			hits_predicted++;
		if (res.status == STATUS_FULL)
			full_predicted++;
		return res;
	endfunction

	function automatic int slots_in_use();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			n += slot_valid[i];
		return n;
	endfunction

	// Send one word: an optional random gap, then hold start until the block takes it.
	task automatic send_word(input logic [1:0] act, input logic [PID_W-1:0] pid,
			input logic [KEY_W-1:0] vkey, input logic [KEY_W-1:0] rkey);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			// Half of the gaps begin once the block is idle, so they fall on every phase.
			if ($urandom_range(0, 1))
				while (busy) @(negedge clk);
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		process_id <= pid;
		virtual_key <= vkey;
		real_key <= rkey;
		do @(posedge clk); while (busy);
		pending_translations.push_back(predict_translation(act, pid, vkey, rkey));
		words_sent++;
	endtask

	// Mostly keys from the pool, sometimes a fresh random key.
	task automatic pick_key(output logic [PID_W-1:0] pid, output logic [KEY_W-1:0] vkey);
		int k;
		if ($urandom_range(0, 9) == 0) begin
			pid = PID_W'($urandom());
			vkey = $urandom();
		end else begin
			k = $urandom_range(0, KEY_POOL - 1);
			pid = pool_pid[k];
			vkey = pool_vkey[k];
		end
	endtask

	function automatic logic [KEY_W-1:0] pick_real_key();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Misses, absent deletes and the unused code on an empty table.
	task automatic test_empty_table();
		send_word(ACT_LOOKUP, '0, '0, '1);
		send_word(ACT_DELETE, '1, '1, '0);
		send_word(ACT_UNUSED, '0, '1, '1);
		send_word(ACT_LOOKUP, '1, '0, 32'h5A5A_A5A5);
	endtask

	// Insert, update, partial key matches, the unused code on a hit, and delete.
	task automatic test_register_update_delete();
		send_word(ACT_REGISTER, '1, '1, '0);
		send_word(ACT_LOOKUP, '1, '1, 32'h1234_5678);
		send_word(ACT_REGISTER, '1, '1, '1);
		send_word(ACT_LOOKUP, '1, '1, '0);
		send_word(ACT_REGISTER, '0, '0, 32'h1234_5678);
		send_word(ACT_REGISTER, '0, 32'h0000_0001, 32'hCAFE_F00D);
		// Same process id or same virtual key alone must not match.
		send_word(ACT_LOOKUP, 22'h00_0001, '0, '0);
		send_word(ACT_LOOKUP, '0, '1, '0);
		send_word(ACT_LOOKUP, '0, 32'h0000_0001, '0);
		send_word(ACT_UNUSED, '0, '0, '0);
		send_word(ACT_DELETE, '0, '0, '1);
		send_word(ACT_LOOKUP, '0, '0, '1);
		send_word(ACT_DELETE, '0, '0, '1);
		// The freed slot is reused by the next new key.
		send_word(ACT_REGISTER, 22'h2A_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
		send_word(ACT_LOOKUP, 22'h2A_AAAA, 32'hAAAA_AAAA, '0);
	endtask

	// Fill every slot, hit the full case, update while full, free one slot, then drain.
	task automatic test_table_full();
		logic [PID_W-1:0] pid;
		logic [KEY_W-1:0] vkey;
		int victim;
		while (slots_in_use() < ENTRIES)
			send_word(ACT_REGISTER, PID_W'($urandom()), $urandom(), pick_real_key());
		send_word(ACT_REGISTER, PID_W'($urandom()), $urandom(), pick_real_key());
		victim = $urandom_range(0, ENTRIES - 1);
		pid = slot_pid[victim];
		vkey = slot_vkey[victim];
		send_word(ACT_REGISTER, pid, vkey, $urandom());
		send_word(ACT_LOOKUP, pid, vkey, '0);
		send_word(ACT_UNUSED, pid, vkey, '0);
		send_word(ACT_DELETE, pid, vkey, '0);
		send_word(ACT_REGISTER, '1, '0, '1);
		send_word(ACT_REGISTER, '0, '1, '0);
		send_word(ACT_LOOKUP, '1, '0, '0);
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_valid[i]) begin
				pid = slot_pid[i];
				vkey = slot_vkey[i];
				send_word(ACT_DELETE, pid, vkey, $urandom());
			end
		end
	endtask

	// Random mix of actions with the given percentages of register and delete.
	task automatic test_random_traffic(input int count, input int reg_pct, input int del_pct,
			input bit with_gaps);
		logic [PID_W-1:0] pid;
		logic [KEY_W-1:0] vkey;
		logic [1:0] act;
		int r;
		gaps_on = with_gaps;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < reg_pct)
				act = ACT_REGISTER;
			else if (r < reg_pct + del_pct)
				act = ACT_DELETE;
			else if (r < 96)
				act = ACT_LOOKUP;
			else
				act = ACT_UNUSED;
			pick_key(pid, vkey);
			send_word(act, pid, vkey, pick_real_key());
			// Stretches without gaps inside the phases too.
			if (with_gaps && n % 50 == 0)
				gaps_on = $urandom_range(0, 2) != 0;
		end
	endtask

	// Compare each result with the oldest expectation; watch for a stalled run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				results_checked++;
				if (pending_translations.size() == 0) begin
					$display("%0t: result with no word outstanding: found %0b key %h status %0b",
						$time, found, translated_key, status);
					errors++;
				end else begin
					oldest_translation = pending_translations.pop_front();
					if (found !== oldest_translation.found) begin
						$display("%0t: found mismatch, expected %0b, got %0b",
							$time, oldest_translation.found, found);
						errors++;
					end
					if (translated_key !== oldest_translation.translated_key) begin
						$display("%0t: translated_key mismatch, expected %h, got %h",
							$time, oldest_translation.translated_key, translated_key);
						errors++;
					end
					if (status !== oldest_translation.status) begin
						$display("%0t: status mismatch, expected %0b, got %0b",
							$time, oldest_translation.status, status);
						errors++;
					end
				end
			end
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding",
					$time, pending_translations.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Reset, then the tests in turn, then drain and report.
	initial begin
		errors = 0;
		words_sent = 0;
		results_checked = 0;
		hits_predicted = 0;
		full_predicted = 0;
		quiet_cycles = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_REGISTER;
		process_id = '0;
		virtual_key = '0;
		real_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_pid[i] = '0;
			slot_vkey[i] = '0;
			slot_rkey[i] = '0;
		end
		// Some pool keys share a process id or a virtual key with their neighbor.
		pool_pid[0] = '0;
		pool_vkey[0] = '0;
		pool_pid[1] = '1;
		pool_vkey[1] = '1;
		for (int k = 2; k < KEY_POOL; k++) begin
			pool_pid[k] = PID_W'($urandom());
			pool_vkey[k] = $urandom();
			case ($urandom_range(0, 3))
				0: pool_pid[k] = pool_pid[k - 1];
				1: pool_vkey[k] = pool_vkey[k - 1];
				default: ;
			endcase
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_register_update_delete();
		test_table_full();
		test_random_traffic(300, 60, 10, 1'b1);
		test_random_traffic(250, 20, 50, 1'b1);
		test_random_traffic(300, 45, 25, 1'b1);
		test_random_traffic(200, 70, 5, 1'b1);
		test_random_traffic(200, 40, 30, 1'b0);

		@(negedge clk);
		start <= 1'b0;
		while (pending_translations.size() != 0) @(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("Sent %0d words and checked %0d results: %0d key hits, %0d table-full reports.",
			words_sent, results_checked, hits_predicted, full_predicted);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rktt_pkg.sv
rtl/core/rktt_ram.sv
rtl/core/remote_key_translation_table.sv
dv/remote_key_translation_table_tb.sv
